@@ hdl/nmea_sentence_checksum_checker_assert.svh @@
// Assertion macros for the NMEA sentence checksum checker
`ifndef NMEA_SENTENCE_CHECKSUM_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECKER_ASSERT_SVH

// clocked check, switched off while reset is held
`define NMEA_CKS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also covers reset cycles
`define NMEA_CKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/nmea_cks_pkg.sv @@
// Package: shared constants, types and helpers of the NMEA checksum checker
`default_nettype none

package nmea_cks_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_F   = 8'h46;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_BAD_HEX  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam logic CFG_MAX_LENGTH    = 1'b0;
  localparam logic CFG_VERIFY_ENABLE = 1'b1;

  localparam logic [7:0] MAX_LENGTH_RST    = 8'd128;
  localparam logic       VERIFY_ENABLE_RST = 1'b1;

  localparam logic [15:0] ERR_COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] max_length;
    logic       verify_enable;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] v;
    h = '0;
    v = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      v = c - CHAR_ZERO;
      h.ok = 1'b1;
    end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
      v = c - CHAR_UC_A + HEX_ALPHA_BASE;
      h.ok = 1'b1;
    end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
      v = c - CHAR_LC_A + HEX_ALPHA_BASE;
      h.ok = 1'b1;
    end
    h.value = v[3:0];
    return h;
  endfunction

endpackage

`default_nettype wire

@@ hdl/nmea_cks_if.sv @@
// Interfaces: received byte channel and result channel
`default_nettype none

interface nmea_cks_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nmea_cks_out_if;
  logic        valid;
  logic        ready;
  logic        char_valid;
  logic [7:0]  char_out;
  logic        done_res;
  logic [1:0]  status;
  logic [7:0]  length;
  logic [15:0] error_count;
  modport source (output valid, output char_valid, output char_out, output done_res,
                  output status, output length, output error_count, input ready);
  modport sink   (input valid, input char_valid, input char_out, input done_res,
                  input status, input length, input error_count, output ready);
endinterface

`default_nettype wire

@@ hdl/nmea_sentence_checksum_checker.sv @@
// An accepted byte passes through the input register and then the result register.
// Throughput: one byte per cycle unless the output stalls; some bytes open no result.
// The input register and the result register let input and output stall apart.
// Reset (synchronous, rst_n low) returns to hunting, clears the error count and
// loads max_length 128 and verify_enable 1.
`default_nettype none

module nmea_sentence_checksum_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  nmea_cks_in_if.sink      in_byte,
  nmea_cks_out_if.source   out_res,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  logic [7:0] max_length_r;
  logic       verify_enable_r;

  nmea_cks_pkg::cfg_t   cfg;
  nmea_cks_pkg::stage_t stage;
  logic                 stage_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r    <= nmea_cks_pkg::MAX_LENGTH_RST;
      verify_enable_r <= nmea_cks_pkg::VERIFY_ENABLE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        nmea_cks_pkg::CFG_MAX_LENGTH:    max_length_r    <= cfg_wdata;
        nmea_cks_pkg::CFG_VERIFY_ENABLE: verify_enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = '{max_length: max_length_r, verify_enable: verify_enable_r};

  nmea_cks_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_byte     (in_byte),
    .stage       (stage),
    .stage_ready (stage_ready)
  );

  nmea_cks_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .stage       (stage),
    .stage_ready (stage_ready),
    .out_res     (out_res)
  );

endmodule

`default_nettype wire

@@ hdl/nmea_cks_in_stage.sv @@
// Input register stage for received bytes
`default_nettype none

module nmea_cks_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  nmea_cks_in_if.sink         in_byte,
  output nmea_cks_pkg::stage_t stage,
  input  wire logic           stage_ready
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  assign in_byte.ready = !valid_r || stage_ready;
  assign take          = in_byte.valid && in_byte.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (stage_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_byte.rx_byte;
    end
  end

  assign stage = '{valid: valid_r, rx_byte: byte_r};

endmodule

`default_nettype wire

@@ hdl/nmea_cks_core.sv @@
// Sentence tracker: checksum, digit parse, length limit and result register
`default_nettype none

module nmea_cks_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire nmea_cks_pkg::cfg_t   cfg,
  input  wire nmea_cks_pkg::stage_t stage,
  output logic                      stage_ready,
  nmea_cks_out_if.source            out_res
);

  logic        in_sentence_r, in_sentence_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [7:0]  sent_sum_r, sent_sum_nxt;
  logic [1:0]  digits_left_r, digits_left_nxt;
  logic        seen_star_r, seen_star_nxt;
  logic        sum_complete_r, sum_complete_nxt;
  logic [7:0]  stored_count_r, stored_count_nxt;
  logic [15:0] mismatch_count_r, mismatch_count_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        char_valid_r, char_valid_nxt;
  logic [7:0]  char_out_r, char_out_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  status_r, status_nxt;

  logic        fire;
  logic        emit;
  logic [7:0]  c;
  nmea_cks_pkg::hex_t hex;

  assign stage_ready = !out_valid_r || out_res.ready;
  assign fire        = stage.valid && stage_ready;
  assign c           = stage.rx_byte;
  assign hex         = nmea_cks_pkg::hex_decode(c);

  always_comb begin
    in_sentence_nxt    = in_sentence_r;
    running_xor_nxt    = running_xor_r;
    sent_sum_nxt       = sent_sum_r;
    digits_left_nxt    = digits_left_r;
    seen_star_nxt      = seen_star_r;
    sum_complete_nxt   = sum_complete_r;
    stored_count_nxt   = stored_count_r;
    mismatch_count_nxt = mismatch_count_r;
    emit               = 1'b0;
    char_valid_nxt     = 1'b0;
    char_out_nxt       = '0;
    done_nxt           = 1'b0;
    status_nxt         = nmea_cks_pkg::ST_OK;

    if (fire) begin
      if (!in_sentence_r) begin
        // hunt: open on dollar, drop anything else
        if (c == nmea_cks_pkg::CHAR_DOLLAR) begin
          emit             = 1'b1;
          in_sentence_nxt  = 1'b1;
          running_xor_nxt  = '0;
          sent_sum_nxt     = '0;
          digits_left_nxt  = '0;
          seen_star_nxt    = 1'b0;
          sum_complete_nxt = 1'b0;
          stored_count_nxt = 8'd1;
          char_valid_nxt   = 1'b1;
          char_out_nxt     = c;
          if (8'd1 >= cfg.max_length) begin
            in_sentence_nxt = 1'b0;
            done_nxt        = 1'b1;
            status_nxt      = nmea_cks_pkg::ST_OVERFLOW;
          end
        end
      end else if (c == nmea_cks_pkg::CHAR_CR || c == nmea_cks_pkg::CHAR_LF ||
                   sum_complete_r) begin
        // end of sentence: swallow byte, compare sums when verify_enable is set
        emit            = 1'b1;
        in_sentence_nxt = 1'b0;
        done_nxt        = 1'b1;
        if (cfg.verify_enable && running_xor_r != sent_sum_r) begin
          status_nxt = nmea_cks_pkg::ST_MISMATCH;
          if (mismatch_count_r != nmea_cks_pkg::ERR_COUNT_MAX) begin
            mismatch_count_nxt = mismatch_count_r + 16'd1;
          end
        end
      end else if (digits_left_r != 2'd0 && !hex.ok) begin
        emit             = 1'b1;
        in_sentence_nxt  = 1'b0;
        digits_left_nxt  = digits_left_r - 2'd1;
        sum_complete_nxt = (digits_left_r == 2'd1);
        done_nxt         = 1'b1;
        status_nxt       = nmea_cks_pkg::ST_BAD_HEX;
      end else begin
        emit = 1'b1;
        if (digits_left_r != 2'd0) begin
          digits_left_nxt  = digits_left_r - 2'd1;
          sum_complete_nxt = (digits_left_r == 2'd1);
          sent_sum_nxt     = {sent_sum_r[3:0], hex.value};
        end
        if (c == nmea_cks_pkg::CHAR_STAR) begin
          seen_star_nxt   = 1'b1;
          digits_left_nxt = 2'd2;
        end else if (!seen_star_r) begin
          running_xor_nxt = running_xor_r ^ c;
        end
        stored_count_nxt = stored_count_r + 8'd1;
        char_valid_nxt   = 1'b1;
        char_out_nxt     = c;
        if (stored_count_nxt >= cfg.max_length) begin
          in_sentence_nxt = 1'b0;
          done_nxt        = 1'b1;
          status_nxt      = nmea_cks_pkg::ST_OVERFLOW;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r    <= 1'b0;
      running_xor_r    <= '0;
      sent_sum_r       <= '0;
      digits_left_r    <= '0;
      seen_star_r      <= 1'b0;
      sum_complete_r   <= 1'b0;
      stored_count_r   <= '0;
      mismatch_count_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      in_sentence_r    <= in_sentence_nxt;
      running_xor_r    <= running_xor_nxt;
      sent_sum_r       <= sent_sum_nxt;
      digits_left_r    <= digits_left_nxt;
      seen_star_r      <= seen_star_nxt;
      sum_complete_r   <= sum_complete_nxt;
      stored_count_r   <= stored_count_nxt;
      mismatch_count_r <= mismatch_count_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_valid_r <= char_valid_nxt;
      char_out_r   <= char_out_nxt;
      done_r       <= done_nxt;
      status_r     <= status_nxt;
    end
  end

  logic [7:0]  length_r;
  logic [15:0] error_count_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      length_r      <= stored_count_nxt;
      error_count_r <= mismatch_count_nxt;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.char_valid  = char_valid_r;
  assign out_res.char_out    = char_out_r;
  assign out_res.done_res    = done_r;
  assign out_res.status      = status_r;
  assign out_res.length      = length_r;
  assign out_res.error_count = error_count_r;

endmodule

`default_nettype wire

@@ hdl/nmea_cks_checker.sv @@
// Port checker for the NMEA sentence checksum checker, bound to the top level
`default_nettype none
`include "nmea_sentence_checksum_checker_assert.svh"

module nmea_cks_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic        char_valid,
  input  wire logic [7:0]  char_out,
  input  wire logic        done_res,
  input  wire logic [1:0]  status,
  input  wire logic [7:0]  length
);

  `NMEA_CKS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result after reset")

  `NMEA_CKS_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(status) && $stable(length), "stalled beat changed")

  `NMEA_CKS_ASSERT(a_status_needs_done, clk, rst_n, out_valid && !done_res |-> status == nmea_cks_pkg::ST_OK && char_valid, "status or empty beat without end")

  `NMEA_CKS_ASSERT(a_char_has_length, clk, rst_n, out_valid && char_valid |-> length != 8'd0, "stored byte with zero length")

  `NMEA_CKS_ASSERT(a_bad_hex_no_char, clk, rst_n, out_valid && done_res && (status == nmea_cks_pkg::ST_BAD_HEX || status == nmea_cks_pkg::ST_MISMATCH) |-> !char_valid && char_out == 8'd0, "ending beat carries a byte")

endmodule

bind nmea_sentence_checksum_checker nmea_cks_checker u_nmea_cks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_res.valid),
  .out_ready  (out_res.ready),
  .char_valid (out_res.char_valid),
  .char_out   (out_res.char_out),
  .done_res   (out_res.done_res),
  .status     (out_res.status),
  .length     (out_res.length)
);

`default_nettype wire
